[src/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the sparse matrix store
// Field widths, request/result structs, status and register codes.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int MAX_DIMENSION = 256;
  localparam int VALUE_WIDTH   = 32;

  localparam int IDX_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = IDX_W + 1;
  localparam int VAL_W = VALUE_WIDTH;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] write_value;
  } sms_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic                    entry_found;
  } sms_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]        rows_in_use;
    logic [DIM_W-1:0]        columns_in_use;
    logic signed [VAL_W-1:0] default_value;
  } sms_cfg_t;

  // one stored coordinate entry
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } sms_entry_t;

endpackage

[src/sms_ram.sv]
// ----------------------------------------------------------------------------
// sms_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sms_engine.sv]
// ----------------------------------------------------------------------------
// sms_engine: scan and update engine
// Range check, linear scan of the entry RAM, then one read-modify-write.
// ----------------------------------------------------------------------------
module sms_engine import sms_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sms_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sms_in_t  in_data_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output sms_out_t res_o
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW    = $bits(sms_entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  sms_in_t             req_q, req_d;
  sms_out_t            res_q, res_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pidx_q, pidx_d;
  logic                free_ok_q, free_ok_d;
  logic [AW-1:0]       free_idx_q, free_idx_d;
  logic [CAPACITY-1:0] valid_q, valid_d;

  logic             ram_re, ram_we;
  logic [AW-1:0]    ram_raddr, ram_waddr;
  logic [EW-1:0]    ram_rdata_raw;
  sms_entry_t       ram_rdata, ram_wdata;

  logic             out_of_range;
  logic             hit, last, slot_free, avail;
  logic [AW-1:0]    ins_idx;

  assign ram_rdata    = sms_entry_t'(ram_rdata_raw);
  assign out_of_range = ({1'b0, in_data_i.row_index} >= cfg_i.rows_in_use) ||
                        ({1'b0, in_data_i.column_index} >= cfg_i.columns_in_use);

  // compare stage of the scan
  assign slot_free = !valid_q[pidx_q];
  assign hit       = pend_q && valid_q[pidx_q] &&
                     (ram_rdata.row == req_q.row_index) &&
                     (ram_rdata.column == req_q.column_index);
  assign last      = pend_q && (pidx_q == AW'(CAPACITY - 1));
  assign avail     = free_ok_q || slot_free;
  assign ins_idx   = free_ok_q ? free_idx_q : pidx_q;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    ram_re     = 1'b0;
    ram_raddr  = issue_q[AW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = pidx_q;
    ram_wdata  = '{row: req_q.row_index, column: req_q.column_index,
                   value: req_q.write_value};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (out_of_range) begin
            res_d.read_value  = (in_data_i.cmd == CMD_WRITE) ? '0 : cfg_i.default_value;
            res_d.status      = ST_RANGE;
            res_d.entry_found = 1'b0;
            state_d           = S_DONE;
          end else begin
            issue_d   = '0;
            free_ok_d = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_q < CNT_W'(CAPACITY)) begin
          ram_re  = 1'b1;
          pend_d  = 1'b1;
          pidx_d  = issue_q[AW-1:0];
          issue_d = issue_q + CNT_W'(1);
        end
        if (pend_q && slot_free && !free_ok_q) begin
          free_ok_d  = 1'b1;
          free_idx_d = pidx_q;
        end
        if (hit || last) begin
          state_d           = S_DONE;
          pend_d            = 1'b0;
          res_d.read_value  = '0;
          res_d.status      = ST_OK;
          res_d.entry_found = hit;
          if (req_q.cmd == CMD_READ) begin
            res_d.read_value = hit ? ram_rdata.value : cfg_i.default_value;
          end else if (hit) begin
            // writing the default removes the entry
            if (req_q.write_value == cfg_i.default_value) begin
              valid_d[pidx_q] = 1'b0;
            end else begin
              ram_we = 1'b1;
            end
          end else if (req_q.write_value != cfg_i.default_value) begin
            if (avail) begin
              valid_d[ins_idx] = 1'b1;
              ram_we           = 1'b1;
              ram_waddr        = ins_idx;
            end else begin
              res_d.status = ST_FULL;
            end
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      free_ok_q <= 1'b0;
      issue_q   <= '0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      free_ok_q <= free_ok_d;
      issue_q   <= issue_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    pidx_q     <= pidx_d;
    free_idx_q <= free_idx_d;
  end

  sms_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

[src/sparse_matrix_store.sv]
// ----------------------------------------------------------------------------
// sparse_matrix_store: bounded coordinate store for a sparse matrix
// Holds up to CAPACITY (row, column, value) entries over a default value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o, in_data_i) carries a read or write
//   of one cell; each request gives exactly one result on the result channel
//   (out_valid_o/out_ready_i, out_data_o), in order.
//   Config channel (cfg_valid_i/cfg_ready_o) writes rows_in_use, columns_in_use
//   and default_value by index; write it only while no request is in flight.
//   An out-of-range request goes straight to the engine's done state and then
//   to the output register. An in-range request scans the entry RAM one slot
//   per cycle (one RAM read port), up to the matching slot on a hit and over
//   all CAPACITY slots on a miss.
//   One request is processed at a time; in_ready_o rises the cycle after the
//   engine hands its result to the output register, so a new request is not
//   taken until the scan of the previous one has finished.
//   Reset clears all entry valid bits at once (no clearing pass) and loads
//   rows/columns 256 and default 0.
//   While the receiver stalls, the output register holds its result; the
//   engine finishes one more request and then waits.
// ----------------------------------------------------------------------------
module sparse_matrix_store import sms_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sms_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sms_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  sms_cfg_t cfg_q, cfg_d;
  logic     out_valid_q, out_valid_d;
  sms_out_t out_data_q;
  logic     res_valid, res_ready;
  sms_out_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS:    cfg_d.rows_in_use    = cfg_data_i[DIM_W-1:0];
        CFG_COLUMNS: cfg_d.columns_in_use = cfg_data_i[DIM_W-1:0];
        CFG_DEFAULT: cfg_d.default_value  = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // output register, refilled when empty or being drained
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use    <= DIM_W'(MAX_DIMENSION);
      cfg_q.columns_in_use <= DIM_W'(MAX_DIMENSION);
      cfg_q.default_value  <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  sms_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
